// File: rtl/ttds_pkg.sv
// ttds_pkg: shared types and constants of the task table deadline scheduler
// table depth, index widths, status and mode codes, table entry layout
// no dependencies
package ttds_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_SCHED  = 2'd1,
        MODE_DONE   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        POL_DEADLINE = 2'd0,
        POL_PERIOD   = 2'd1,
        POL_ARRIVAL  = 2'd2
    } t_policy;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_FINISHED = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] deadline;
        logic [15:0] period;
        logic [31:0] arrival;
        logic [15:0] remaining;
        logic [15:0] miss_count;
    } t_task_ent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_RUN,
        S_DONE,
        S_FINISH
    } t_state;

endpackage

// File: rtl/ttds_if.sv
// ttds_in_if / ttds_out_if: valid-ready channels of the scheduler
// task request beat and result beat, source and sink modports
// no dependencies
interface ttds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] deadline;
    logic [15:0] period;
    logic [15:0] work_ticks;
    logic [31:0] now;

    modport source (output valid, mode, deadline, period, work_ticks, now, input ready);
    modport sink   (input valid, mode, deadline, period, work_ticks, now, output ready);
endinterface

interface ttds_out_if;
    logic        valid;
    logic        ready;
    logic        error;
    logic [3:0]  task_index;
    logic        switched;
    logic        finished;
    logic [4:0]  new_misses;
    logic [31:0] missed_total;
    logic [15:0] completed_total;

    modport source (output valid, error, task_index, switched, finished, new_misses,
                    missed_total, completed_total, input ready);
    modport sink   (input valid, error, task_index, switched, finished, new_misses,
                    missed_total, completed_total, output ready);
endinterface

// File: rtl/ttds_table.sv
// ttds_table: task table memory, one write and one registered read per cycle
// depends on ttds_pkg (depth, index width, entry layout)
module ttds_table (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ttds_pkg::IDX_W-1:0]    i_wr_addr,
    input  ttds_pkg::t_task_ent           i_wr_data,
    input  logic [ttds_pkg::IDX_W-1:0]    i_rd_addr,
    output ttds_pkg::t_task_ent           o_rd_data
);

    ttds_pkg::t_task_ent r_mem [ttds_pkg::TABLE_DEPTH];
    ttds_pkg::t_task_ent r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/task_table_deadline_scheduler_unit.sv
// task_table_deadline_scheduler_unit: top level of the task table scheduler
// sequencer, shared key compare and counters around the task table memory
// depends on ttds_pkg, ttds_if (channels) and ttds_table
//
// usage
//   i_task carries one request beat: create, schedule, done or no-op
//   o_res returns exactly one result beat per request, in order
//   i_cfg_we / i_cfg_wdata write the selection policy; write it only while idle, the block does not enforce this
// timing
//   create, no-op and an empty-table schedule: from accept through the
//   finish state straight back to idle
//   done: one read of the current entry, then its update
//   schedule: a scan, a pick and, when it switches tasks, a run step; the
//   table is walked one entry per cycle through the single read port, each
//   entry going through the shared key compare and the miss check
//   the result is registered and appears the cycle after the step ends
// reset
//   synchronous active-low reset empties the table, clears the counters,
//   sets policy to earliest deadline and the current task to index 0
// stalls
//   a result that is not taken holds on o_res; the next request is still
//   accepted and worked on, and waits for the output register to free
module task_table_deadline_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    ttds_in_if.sink     i_task,
    ttds_out_if.source  o_res
);

    localparam int IDX_W = ttds_pkg::IDX_W;
    localparam int CNT_W = ttds_pkg::CNT_W;

    // selection key of an entry under the current policy
    function automatic logic [31:0] sel_key(input logic [1:0] pol,
                                            input ttds_pkg::t_task_ent ent);
        logic [31:0] k;
        case (pol)
            ttds_pkg::POL_DEADLINE: k = ent.deadline;
            ttds_pkg::POL_PERIOD:   k = 32'(ent.period);
            default:                k = ent.arrival;  // arrival, also the spare code
        endcase
        return k;
    endfunction

    // control state
    ttds_pkg::t_state r_state, n_state;
    logic [1:0]       r_policy;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [31:0]      r_miss_total, n_miss_total;
    logic [15:0]      r_comp_total, n_comp_total;
    logic             r_out_valid, n_out_valid;

    // scan walk
    logic [CNT_W-1:0] r_scan_addr, n_scan_addr;
    logic             r_proc_vld, n_proc_vld;
    logic [IDX_W-1:0] r_proc_idx, n_proc_idx;
    logic             r_found, n_found;
    logic [31:0]      r_best_key, n_best_key;
    logic [IDX_W-1:0] r_best, n_best;
    ttds_pkg::t_task_ent r_best_ent, n_best_ent;
    logic             r_cur_ok, n_cur_ok;
    ttds_pkg::t_task_ent r_cur_ent, n_cur_ent;
    logic [31:0]      r_now, n_now;

    // step result
    logic             r_err, n_err;
    logic             r_sw, n_sw;
    logic             r_fin, n_fin;
    logic [4:0]       r_misses, n_misses;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;

    // output register
    logic             r_o_err;
    logic [3:0]       r_o_idx;
    logic             r_o_sw;
    logic             r_o_fin;
    logic [4:0]       r_o_misses;
    logic [31:0]      r_o_miss_total;
    logic [15:0]      r_o_comp_total;
    logic             out_load;

    // table port
    logic                tbl_wr_en;
    logic [IDX_W-1:0]    tbl_wr_addr;
    ttds_pkg::t_task_ent tbl_wr_data;
    logic [IDX_W-1:0]    tbl_rd_addr;
    ttds_pkg::t_task_ent tbl_rd_data;

    // shared compare unit on the entry coming out of the table
    ttds_pkg::t_task_ent sc_upd;
    logic [31:0]         sc_key;
    logic                sc_ready;
    logic                sc_less;
    logic                sc_miss;
    ttds_pkg::t_task_ent run_ent;
    ttds_pkg::t_task_ent new_ent;

    ttds_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd_data)
    );

    always_comb begin
        sc_ready = (tbl_rd_data.status == ttds_pkg::ST_READY);
        sc_key   = sel_key(r_policy, tbl_rd_data);
        sc_less  = (sc_key < r_best_key);
        sc_miss  = (r_policy == ttds_pkg::POL_DEADLINE) && sc_ready
                   && (r_now > tbl_rd_data.deadline);
        sc_upd   = tbl_rd_data;
        if (sc_miss && (tbl_rd_data.miss_count != 16'hFFFF)) begin
            sc_upd.miss_count = tbl_rd_data.miss_count + 16'd1;
        end
    end

    always_comb begin
        new_ent.status     = ttds_pkg::ST_READY;
        new_ent.deadline   = i_task.deadline;
        new_ent.period     = i_task.period;
        new_ent.arrival    = i_task.now;
        new_ent.remaining  = i_task.work_ticks;
        new_ent.miss_count = 16'd0;
    end

    // sequencer: next state, table accesses and counters
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur        = r_cur;
        n_miss_total = r_miss_total;
        n_comp_total = r_comp_total;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_scan_addr  = r_scan_addr;
        n_proc_vld   = r_proc_vld;
        n_proc_idx   = r_proc_idx;
        n_found      = r_found;
        n_best_key   = r_best_key;
        n_best       = r_best;
        n_best_ent   = r_best_ent;
        n_cur_ok     = r_cur_ok;
        n_cur_ent    = r_cur_ent;
        n_now        = r_now;
        n_err        = r_err;
        n_sw         = r_sw;
        n_fin        = r_fin;
        n_misses     = r_misses;
        n_res_idx    = r_res_idx;
        out_load     = 1'b0;
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = r_cur;
        tbl_wr_data  = new_ent;
        tbl_rd_addr  = r_cur;
        run_ent      = r_best_ent;
        i_task.ready = (r_state == ttds_pkg::S_IDLE);

        case (r_state)
            ttds_pkg::S_IDLE: begin
                if (i_task.valid) begin
                    n_err     = 1'b0;
                    n_sw      = 1'b0;
                    n_fin     = 1'b0;
                    n_misses  = 5'd0;
                    n_res_idx = r_cur;
                    n_now     = i_task.now;
                    case (ttds_pkg::t_mode'(i_task.mode))
                        ttds_pkg::MODE_CREATE: begin
                            if (r_count >= CNT_W'(ttds_pkg::TABLE_DEPTH)) begin
                                n_err = 1'b1;
                            end else begin
                                tbl_wr_en   = 1'b1;
                                tbl_wr_addr = r_count[IDX_W-1:0];
                                tbl_wr_data = new_ent;
                                n_count     = r_count + CNT_W'(1);
                                n_res_idx   = r_count[IDX_W-1:0];
                            end
                            n_state = ttds_pkg::S_FINISH;
                        end
                        ttds_pkg::MODE_SCHED: begin
                            if (r_count == '0) begin
                                n_err   = 1'b1;
                                n_state = ttds_pkg::S_FINISH;
                            end else begin
                                n_scan_addr = '0;
                                n_proc_vld  = 1'b0;
                                n_found     = 1'b0;
                                n_cur_ok    = 1'b0;
                                n_state     = ttds_pkg::S_SCAN;
                            end
                        end
                        ttds_pkg::MODE_DONE: begin
                            // current entry is being read this cycle
                            n_state = ttds_pkg::S_DONE;
                        end
                        default: begin
                            n_state = ttds_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            ttds_pkg::S_SCAN: begin
                // issue side
                if (r_scan_addr < r_count) begin
                    tbl_rd_addr = r_scan_addr[IDX_W-1:0];
                    n_proc_vld  = 1'b1;
                    n_proc_idx  = r_scan_addr[IDX_W-1:0];
                    n_scan_addr = r_scan_addr + CNT_W'(1);
                end else begin
                    n_proc_vld = 1'b0;
                    if (!r_proc_vld) begin
                        n_state = ttds_pkg::S_PICK;
                    end
                end
                // process side, entry read in the previous cycle
                if (r_proc_vld) begin
                    if (sc_miss) begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_addr = r_proc_idx;
                        tbl_wr_data = sc_upd;
                        if (r_misses != 5'd31) begin
                            n_misses = r_misses + 5'd1;
                        end
                        if (r_miss_total != 32'hFFFF_FFFF) begin
                            n_miss_total = r_miss_total + 32'd1;
                        end
                    end
                    if (sc_ready && (!r_found || sc_less)) begin
                        n_found    = 1'b1;
                        n_best_key = sc_key;
                        n_best     = r_proc_idx;
                        n_best_ent = sc_upd;
                    end
                    if (r_proc_idx == r_cur) begin
                        n_cur_ok  = (tbl_rd_data.status != ttds_pkg::ST_FINISHED);
                        n_cur_ent = sc_upd;
                    end
                end
            end

            ttds_pkg::S_PICK: begin
                if (r_found && (r_best != r_cur)) begin
                    // old current goes back to ready unless finished
                    if (r_cur_ok) begin
                        tbl_wr_en          = 1'b1;
                        tbl_wr_addr        = r_cur;
                        tbl_wr_data        = r_cur_ent;
                        tbl_wr_data.status = ttds_pkg::ST_READY;
                    end
                    n_state = ttds_pkg::S_RUN;
                end else begin
                    n_state = ttds_pkg::S_FINISH;
                end
            end

            ttds_pkg::S_RUN: begin
                if (r_best_ent.remaining <= 16'd1) begin
                    run_ent.remaining = 16'd0;
                    run_ent.status    = ttds_pkg::ST_FINISHED;
                    n_fin             = 1'b1;
                    if (r_comp_total != 16'hFFFF) begin
                        n_comp_total = r_comp_total + 16'd1;
                    end
                end else begin
                    run_ent.remaining = r_best_ent.remaining - 16'd1;
                    run_ent.status    = ttds_pkg::ST_RUNNING;
                end
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = r_best;
                tbl_wr_data = run_ent;
                n_cur       = r_best;
                n_res_idx   = r_best;
                n_sw        = 1'b1;
                n_state     = ttds_pkg::S_FINISH;
            end

            ttds_pkg::S_DONE: begin
                if ((CNT_W'(r_cur) < r_count)
                    && (tbl_rd_data.status != ttds_pkg::ST_FINISHED)) begin
                    tbl_wr_en          = 1'b1;
                    tbl_wr_addr        = r_cur;
                    tbl_wr_data        = tbl_rd_data;
                    tbl_wr_data.status = ttds_pkg::ST_FINISHED;
                    n_fin              = 1'b1;
                    if (r_comp_total != 16'hFFFF) begin
                        n_comp_total = r_comp_total + 16'd1;
                    end
                end
                n_state = ttds_pkg::S_FINISH;
            end

            ttds_pkg::S_FINISH: begin
                // hand over once the output register is free
                if (!r_out_valid || o_res.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ttds_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ttds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ttds_pkg::S_IDLE;
            r_policy     <= ttds_pkg::POL_DEADLINE;
            r_count      <= '0;
            r_cur        <= '0;
            r_miss_total <= '0;
            r_comp_total <= '0;
            r_out_valid  <= 1'b0;
            r_proc_vld   <= 1'b0;
            r_found      <= 1'b0;
            r_cur_ok     <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            r_count      <= n_count;
            r_cur        <= n_cur;
            r_miss_total <= n_miss_total;
            r_comp_total <= n_comp_total;
            r_out_valid  <= n_out_valid;
            r_proc_vld   <= n_proc_vld;
            r_found      <= n_found;
            r_cur_ok     <= n_cur_ok;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_proc_idx  <= n_proc_idx;
        r_best_key  <= n_best_key;
        r_best      <= n_best;
        r_best_ent  <= n_best_ent;
        r_cur_ent   <= n_cur_ent;
        r_now       <= n_now;
        r_err       <= n_err;
        r_sw        <= n_sw;
        r_fin       <= n_fin;
        r_misses    <= n_misses;
        r_res_idx   <= n_res_idx;
        if (out_load) begin
            r_o_err        <= r_err;
            r_o_idx        <= 4'(r_res_idx);
            r_o_sw         <= r_sw;
            r_o_fin        <= r_fin;
            r_o_misses     <= r_misses;
            r_o_miss_total <= r_miss_total;
            r_o_comp_total <= r_comp_total;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.error           = r_o_err;
    assign o_res.task_index      = r_o_idx;
    assign o_res.switched        = r_o_sw;
    assign o_res.finished        = r_o_fin;
    assign o_res.new_misses      = r_o_misses;
    assign o_res.missed_total    = r_o_miss_total;
    assign o_res.completed_total = r_o_comp_total;

`ifndef ASSERT_OFF
    // table fill never runs past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ttds_pkg::TABLE_DEPTH))
        else $error("task count beyond table depth");

    // current task lies inside the filled part of the table once it holds a task
    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CNT_W'(r_cur) < r_count))
        else $error("current index outside filled table");

    // completion count only grows
    a_comp_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_comp_total >= $past(r_comp_total)))
        else $error("completion count went down");

    // a finishing or switching step is never an error step
    a_fin_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_fin || r_o_sw)) |-> !r_o_err)
        else $error("error reported with finish or switch");
`endif

endmodule
